// File: hdl/arc_pkg.sv
// arc_pkg: shared types, codes and constants of the arp resolution cache
// used by arp_resolution_cache_top; depends on nothing
package arc_pkg;

   localparam int CACHE_ENTRIES_DEF   = 16;
   localparam int REQUEST_ENTRIES_DEF = 8;
   localparam int PARKED_ENTRIES_DEF  = 16;

   localparam logic [15:0] TTL_RESET   = 16'd30000;
   localparam logic [15:0] RETRY_RESET = 16'd5000;
   localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_SEND = 2'd0,
      CMD_RECV = 2'd1,
      CMD_TICK = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      FT_IPV4  = 2'd0,
      FT_ARP   = 2'd1,
      FT_OTHER = 2'd2,
      FT_RSVD  = 2'd3
   } ftype_type;

   typedef enum logic [2:0] {
      KIND_SEND    = 3'd0,
      KIND_ARP_REQ = 3'd1,
      KIND_ARP_REP = 3'd2,
      KIND_DELIVER = 3'd3,
      KIND_DROP    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      REG_OWN_MAC = 2'd0,
      REG_OWN_IP  = 2'd1,
      REG_TTL     = 2'd2,
      REG_RETRY   = 2'd3
   } reg_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] hop_ip;
      logic [15:0] packet_tag;
      logic [47:0] frame_dst_mac;
      logic [47:0] frame_src_mac;
      logic [1:0]  frame_type;
      logic        parse_ok;
      logic        arp_is_request;
      logic [31:0] arp_sender_ip;
      logic [47:0] arp_sender_mac;
      logic [31:0] arp_target_ip;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [47:0] dst_mac;
      logic [31:0] target_ip;
      logic [15:0] out_tag;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [15:0] age;
   } cache_entry_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] tag;
   } parked_entry_type;

   function automatic rsp_type make_rsp(kind_type k, logic [47:0] mac,
                                        logic [31:0] ip, logic [15:0] tag);
      rsp_type r;
      r.kind      = k;
      r.dst_mac   = mac;
      r.target_ip = ip;
      r.out_tag   = tag;
      r.last      = 1'b0;
      return r;
   endfunction

   function automatic logic [15:0] sat_add16(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

endpackage

// File: hdl/arc_ram.sv
// arc_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module arc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/arp_resolution_cache_top.sv
// arp_resolution_cache_top: arp resolver with cache and parked-datagram store
// depends on arc_pkg and arc_ram
//
// usage
//   req channel: one command transaction (send, receive, tick) at a time;
//   req_stall is high from acceptance until the last result has left the
//   internal holding register.
//   rsp channel: zero or more result transactions per command, the final one
//   flagged by last. a result register sits on the port, so rsp_stall only
//   holds the sequencer when a second result is waiting behind it.
//   csr: apb-style register port, pready always high; the user keeps writes
//   only while idle, which the block itself does not enforce.
//   sends, arp receives and ticks first sweep the cache memory and the
//   request table, one entry a cycle. a send then goes through ST_SEND, on a
//   miss ST_PARK, and ST_FLUSH; an arp receive through ST_LWR, ST_PRD and
//   ST_PCHK per parked datagram, ST_RCLR, ST_REPLY and ST_FLUSH. ipv4
//   receives go straight from idle to ST_FLUSH.
// reset
//   synchronous; clears all valid bits and the parked count at once, no sweep.
module arp_resolution_cache_top
   import arc_pkg::*;
#(
   parameter int CACHE_ENTRIES   = CACHE_ENTRIES_DEF,
   parameter int REQUEST_ENTRIES = REQUEST_ENTRIES_DEF,
   parameter int PARKED_ENTRIES  = PARKED_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int RW  = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
   localparam int PW  = (PARKED_ENTRIES > 1) ? $clog2(PARKED_ENTRIES) : 1;
   localparam int SL  = (CACHE_ENTRIES > REQUEST_ENTRIES) ? CACHE_ENTRIES
                                                          : REQUEST_ENTRIES;
   localparam int SW  = $clog2(SL + 1);
   localparam int PCW = $clog2(PARKED_ENTRIES + 1);
   localparam int CEW = $bits(cache_entry_type);
   localparam int PEW = $bits(parked_entry_type);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_SEND, ST_PARK, ST_LWR, ST_PRD, ST_PCHK,
      ST_RCLR, ST_REPLY, ST_FLUSH
   } state_type;

   state_type        state_ff;
   req_type          in_ff;
   logic [31:0]      key_ff;
   logic [47:0]      own_mac_ff;
   logic [31:0]      own_ip_ff;
   logic [15:0]      ttl_ff;
   logic [15:0]      retry_ff;

   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic             pend_vld_ff;
   rsp_type          pend_ff;

   logic [CACHE_ENTRIES-1:0]   cvld_ff;
   logic [REQUEST_ENTRIES-1:0] rvld_ff;
   logic [31:0]                rip_ff  [REQUEST_ENTRIES];
   logic [15:0]                rage_ff [REQUEST_ENTRIES];
   logic [PCW-1:0]             pcnt_ff;

   logic [SW-1:0]    scan_ff;
   logic             dvld_ff;
   logic [SW-1:0]    didx_ff;
   logic             hit_ff;
   logic [CW-1:0]    hidx_ff;
   logic [47:0]      hmac_ff;
   logic             cfree_ff;
   logic [CW-1:0]    cfidx_ff;
   logic [CW-1:0]    coidx_ff;
   logic [15:0]      coage_ff;
   logic             rfound_ff;
   logic [RW-1:0]    ridx_ff;
   logic             rfree_ff;
   logic [RW-1:0]    rfidx_ff;
   logic [RW-1:0]    roidx_ff;
   logic [15:0]      roage_ff;

   logic [PCW-1:0]   pi_ff;
   logic [PCW-1:0]   pw_ff;
   logic             any_ff;

   logic             cache_we;
   logic [CW-1:0]    cache_waddr;
   cache_entry_type  cache_wdata;
   logic [CW-1:0]    cache_raddr;
   cache_entry_type  cache_rdata;
   logic             park_we;
   logic [PW-1:0]    park_waddr;
   parked_entry_type park_wdata;
   parked_entry_type park_rdata;

   logic             out_free;
   logic             prod_ok;
   logic             accept;
   logic             csr_wr;
   logic             dcache;
   logic [CW-1:0]    dci;
   logic [RW-1:0]    sri;
   logic [15:0]      tick_age;
   logic [CW-1:0]    lslot;
   logic [RW-1:0]    rslot;
   logic             push;
   rsp_type          push_data;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign prod_ok  = !pend_vld_ff || out_free;
   assign accept   = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   assign dcache   = dvld_ff && (didx_ff < SW'(CACHE_ENTRIES));
   assign dci      = didx_ff[CW-1:0];
   assign sri      = scan_ff[RW-1:0];
   assign tick_age = sat_add16(cache_rdata.age, in_ff.elapsed_ms);
   assign lslot    = hit_ff ? hidx_ff : (cfree_ff ? cfidx_ff : coidx_ff);
   assign rslot    = rfound_ff ? ridx_ff : (rfree_ff ? rfidx_ff : roidx_ff);

   always_comb begin
      unique case (reg_type'(csr_paddr[4:3]))
         REG_OWN_MAC: csr_prdata = {16'd0, own_mac_ff};
         REG_OWN_IP:  csr_prdata = {32'd0, own_ip_ff};
         REG_TTL:     csr_prdata = {48'd0, ttl_ff};
         REG_RETRY:   csr_prdata = {48'd0, retry_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // moves the waiting result into the port register
   always_comb begin
      push           = 1'b0;
      push_data      = pend_ff;
      push_data.last = 1'b0;
      unique case (state_ff)
         ST_PARK:  push = (pcnt_ff >= PCW'(PARKED_ENTRIES));
         ST_PCHK:  push = (park_rdata.ip == key_ff);
         ST_REPLY: push = in_ff.arp_is_request && in_ff.arp_target_ip == own_ip_ff;
         ST_FLUSH: begin
            push           = 1'b1;
            push_data.last = 1'b1;
         end
         default: ;
      endcase
      push = push && pend_vld_ff && out_free;
   end

   always_comb begin
      cache_raddr = scan_ff[CW-1:0];
      cache_we    = 1'b0;
      cache_waddr = dci;
      cache_wdata = cache_rdata;
      if (state_ff == ST_SCAN && in_ff.cmd == CMD_TICK && dcache && cvld_ff[dci]) begin
         cache_we        = 1'b1;
         cache_wdata.age = tick_age;
      end else if (state_ff == ST_LWR) begin
         cache_we    = 1'b1;
         cache_waddr = lslot;
         cache_wdata = '{ip: in_ff.arp_sender_ip, mac: in_ff.arp_sender_mac, age: 16'd0};
      end
   end

   always_comb begin
      park_we    = 1'b0;
      park_waddr = pcnt_ff[PW-1:0];
      park_wdata = '{ip: in_ff.hop_ip, tag: in_ff.packet_tag};
      if (state_ff == ST_PARK && pcnt_ff < PCW'(PARKED_ENTRIES)) begin
         park_we = 1'b1;
      end else if (state_ff == ST_PCHK && park_rdata.ip != key_ff) begin
         park_we    = 1'b1;
         park_waddr = pw_ff[PW-1:0];
         park_wdata = park_rdata;
      end
   end

   arc_ram #(.WIDTH(CEW), .DEPTH(CACHE_ENTRIES)) u_cache_ram (
      .clock (clock),
      .we    (cache_we),
      .waddr (cache_waddr),
      .wdata (cache_wdata),
      .raddr (cache_raddr),
      .rdata (cache_rdata)
   );

   arc_ram #(.WIDTH(PEW), .DEPTH(PARKED_ENTRIES)) u_park_ram (
      .clock (clock),
      .we    (park_we),
      .waddr (park_waddr),
      .wdata (park_wdata),
      .raddr (pi_ff[PW-1:0]),
      .rdata (park_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= push_data;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_vld_ff  <= 1'b0;
         cvld_ff      <= '0;
         rvld_ff      <= '0;
         pcnt_ff      <= '0;
         dvld_ff      <= 1'b0;
         own_mac_ff   <= '0;
         own_ip_ff    <= '0;
         ttl_ff       <= TTL_RESET;
         retry_ff     <= RETRY_RESET;
      end else begin
         if (csr_wr) begin
            unique case (reg_type'(csr_paddr[4:3]))
               REG_OWN_MAC: own_mac_ff <= csr_pwdata[47:0];
               REG_OWN_IP:  own_ip_ff  <= csr_pwdata[31:0];
               REG_TTL:     ttl_ff     <= csr_pwdata[15:0];
               REG_RETRY:   retry_ff   <= csr_pwdata[15:0];
               default:     ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               scan_ff   <= '0;
               dvld_ff   <= 1'b0;
               hit_ff    <= 1'b0;
               cfree_ff  <= 1'b0;
               rfound_ff <= 1'b0;
               rfree_ff  <= 1'b0;
               any_ff    <= 1'b0;
               pi_ff     <= '0;
               pw_ff     <= '0;
               if (accept) begin
                  in_ff  <= req_data;
                  key_ff <= (req_data.cmd == CMD_SEND) ? req_data.hop_ip
                                                       : req_data.arp_sender_ip;
                  case (cmd_type'(req_data.cmd))
                     CMD_SEND: state_ff <= ST_SCAN;
                     CMD_RECV: begin
                        if (req_data.frame_dst_mac == own_mac_ff ||
                            req_data.frame_dst_mac == MAC_BCAST) begin
                           if (req_data.frame_type == FT_IPV4 && req_data.parse_ok) begin
                              pend_ff     <= make_rsp(KIND_DELIVER, '0, '0,
                                                      req_data.packet_tag);
                              pend_vld_ff <= 1'b1;
                              state_ff    <= ST_FLUSH;
                           end else if (req_data.frame_type == FT_ARP &&
                                        req_data.parse_ok) begin
                              state_ff <= ST_SCAN;
                           end
                        end
                     end
                     CMD_TICK: begin
                        for (int r = 0; r < REQUEST_ENTRIES; r++) begin
                           if (rvld_ff[r]) begin
                              rage_ff[r] <= sat_add16(rage_ff[r], req_data.elapsed_ms);
                           end
                        end
                        state_ff <= ST_SCAN;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SCAN: begin
               if (scan_ff != SW'(SL)) begin
                  scan_ff <= scan_ff + 1'b1;
                  dvld_ff <= 1'b1;
                  didx_ff <= scan_ff;
               end else begin
                  dvld_ff <= 1'b0;
               end
               if (scan_ff < SW'(REQUEST_ENTRIES)) begin
                  if (rvld_ff[sri] && rip_ff[sri] == key_ff && !rfound_ff) begin
                     rfound_ff <= 1'b1;
                     ridx_ff   <= sri;
                  end
                  if (!rvld_ff[sri] && !rfree_ff) begin
                     rfree_ff <= 1'b1;
                     rfidx_ff <= sri;
                  end
                  if (scan_ff == '0 || rage_ff[sri] > roage_ff) begin
                     roidx_ff <= sri;
                     roage_ff <= rage_ff[sri];
                  end
               end
               if (dcache) begin
                  if (cvld_ff[dci] && cache_rdata.ip == key_ff && !hit_ff) begin
                     hit_ff  <= 1'b1;
                     hidx_ff <= dci;
                     hmac_ff <= cache_rdata.mac;
                  end
                  if (!cvld_ff[dci] && !cfree_ff) begin
                     cfree_ff <= 1'b1;
                     cfidx_ff <= dci;
                  end
                  if (didx_ff == '0 || cache_rdata.age > coage_ff) begin
                     coidx_ff <= dci;
                     coage_ff <= cache_rdata.age;
                  end
                  if (in_ff.cmd == CMD_TICK && cvld_ff[dci] && tick_age > ttl_ff) begin
                     cvld_ff[dci] <= 1'b0;
                  end
               end
               if (scan_ff == SW'(SL) && !dvld_ff) begin
                  case (cmd_type'(in_ff.cmd))
                     CMD_SEND: state_ff <= ST_SEND;
                     CMD_RECV: state_ff <= ST_LWR;
                     default:  state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_SEND: begin
               if (hit_ff) begin
                  pend_ff     <= make_rsp(KIND_SEND, hmac_ff, '0, in_ff.packet_tag);
                  pend_vld_ff <= 1'b1;
                  state_ff    <= ST_FLUSH;
               end else if (!rfound_ff || rage_ff[ridx_ff] > retry_ff) begin
                  rvld_ff[rslot] <= 1'b1;
                  rip_ff[rslot]  <= in_ff.hop_ip;
                  rage_ff[rslot] <= '0;
                  pend_ff        <= make_rsp(KIND_ARP_REQ, MAC_BCAST,
                                             in_ff.hop_ip, '0);
                  pend_vld_ff    <= 1'b1;
                  state_ff       <= ST_PARK;
               end else begin
                  state_ff <= ST_PARK;
               end
            end
            ST_PARK: begin
               if (pcnt_ff < PCW'(PARKED_ENTRIES)) begin
                  pcnt_ff  <= pcnt_ff + 1'b1;
                  state_ff <= ST_FLUSH;
               end else if (prod_ok) begin
                  pend_ff     <= make_rsp(KIND_DROP, '0, '0, in_ff.packet_tag);
                  pend_vld_ff <= 1'b1;
                  state_ff    <= ST_FLUSH;
               end
            end
            ST_LWR: begin
               cvld_ff[lslot] <= 1'b1;
               state_ff       <= ST_PRD;
            end
            ST_PRD: begin
               if (pi_ff == pcnt_ff) begin
                  pcnt_ff  <= pw_ff;
                  state_ff <= ST_RCLR;
               end else begin
                  state_ff <= ST_PCHK;
               end
            end
            ST_PCHK: begin
               if (park_rdata.ip == key_ff) begin
                  if (prod_ok) begin
                     pend_ff     <= make_rsp(KIND_SEND, in_ff.arp_sender_mac, '0,
                                             park_rdata.tag);
                     pend_vld_ff <= 1'b1;
                     any_ff      <= 1'b1;
                     pi_ff       <= pi_ff + 1'b1;
                     state_ff    <= ST_PRD;
                  end
               end else begin
                  pw_ff    <= pw_ff + 1'b1;
                  pi_ff    <= pi_ff + 1'b1;
                  state_ff <= ST_PRD;
               end
            end
            ST_RCLR: begin
               if (any_ff && rfound_ff) begin
                  rvld_ff[ridx_ff] <= 1'b0;
               end
               state_ff <= ST_REPLY;
            end
            ST_REPLY: begin
               if (in_ff.arp_is_request && in_ff.arp_target_ip == own_ip_ff) begin
                  if (prod_ok) begin
                     pend_ff     <= make_rsp(KIND_ARP_REP, in_ff.frame_src_mac,
                                             in_ff.arp_sender_ip, '0);
                     pend_vld_ff <= 1'b1;
                     state_ff    <= ST_FLUSH;
                  end
               end else begin
                  state_ff <= ST_FLUSH;
               end
            end
            ST_FLUSH: begin
               if (!pend_vld_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  pend_vld_ff <= 1'b0;
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
